/* hw/rtl/gsr_pkg.sv */
// ----------------------------------------------------------------------------
// Gamepad serial responder package
// Shared codes, constants and transfer types for the responder block.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;

  localparam logic [1:0] PAD_DIGITAL  = 2'd0;
  localparam logic [1:0] PAD_ANALOG   = 2'd1;
  localparam logic [1:0] PAD_PRESSURE = 2'd2;

  localparam logic [7:0] HOST_START = 8'h01;

  localparam logic [7:0] CMD_BUTTON_MASK = 8'h40;
  localparam logic [7:0] CMD_STATUS_A    = 8'h41;
  localparam logic [7:0] CMD_READ_PAD    = 8'h42;
  localparam logic [7:0] CMD_SETUP       = 8'h43;
  localparam logic [7:0] CMD_ANALOG_SW   = 8'h44;
  localparam logic [7:0] CMD_STATUS_B    = 8'h45;
  localparam logic [7:0] CMD_CONST_A     = 8'h46;
  localparam logic [7:0] CMD_CONST_B     = 8'h47;
  localparam logic [7:0] CMD_CONST_C     = 8'h4C;
  localparam logic [7:0] CMD_MOTOR_MAP   = 8'h4D;
  localparam logic [7:0] CMD_PRESS_EN    = 8'h4F;

  localparam logic [7:0] ID_DIGITAL  = 8'h41;
  localparam logic [7:0] ID_ANALOG   = 8'h73;
  localparam logic [7:0] ID_PRESSURE = 8'h79;
  localparam logic [7:0] ID_CONFIG   = 8'hF3;

  localparam logic [7:0] BYTE_ACK     = 8'h5A;
  localparam logic [7:0] LOCK_KEY     = 8'h03;
  localparam logic [7:0] ANALOG_ON    = 8'h01;

  localparam logic [4:0] LEN_DIGITAL  = 5'd3;
  localparam logic [4:0] LEN_ANALOG   = 5'd7;
  localparam logic [4:0] LEN_PRESSURE = 5'd19;
  localparam logic [4:0] LEN_CONFIG   = 5'd7;

  typedef logic [5:0][7:0] gsr_motor_t;
  typedef logic [3:0][7:0] gsr_press_t;
  typedef logic [7:0][7:0] gsr_snap_t;

  typedef struct packed {
    logic       restart;
    logic [7:0] host_byte;
    logic [7:0] buttons_first;
    logic [7:0] buttons_second;
    logic [7:0] right_stick_x;
    logic [7:0] right_stick_y;
    logic [7:0] left_stick_x;
    logic [7:0] left_stick_y;
    logic [7:0] left_trigger_level;
    logic [7:0] right_trigger_level;
  } gsr_item_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       responding;
    logic [1:0] current_mode;
    logic       config_active;
    logic       mode_locked;
  } gsr_result_t;

endpackage

/* hw/rtl/gsr_if.sv */
// ----------------------------------------------------------------------------
// Gamepad serial responder channel interfaces
// Valid/ready channels for host bytes with pad values, and for reply bytes.
// ----------------------------------------------------------------------------
interface gsr_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] host_byte;
  logic [7:0] buttons_first;
  logic [7:0] buttons_second;
  logic [7:0] right_stick_x;
  logic [7:0] right_stick_y;
  logic [7:0] left_stick_x;
  logic [7:0] left_stick_y;
  logic [7:0] left_trigger_level;
  logic [7:0] right_trigger_level;

  modport source (
    output valid, restart, host_byte, buttons_first, buttons_second,
           right_stick_x, right_stick_y, left_stick_x, left_stick_y,
           left_trigger_level, right_trigger_level,
    input  ready
  );
  modport sink (
    input  valid, restart, host_byte, buttons_first, buttons_second,
           right_stick_x, right_stick_y, left_stick_x, left_stick_y,
           left_trigger_level, right_trigger_level,
    output ready
  );
endinterface

interface gsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       responding;
  logic [1:0] current_mode;
  logic       config_active;
  logic       mode_locked;

  modport source (
    output valid, reply_byte, responding, current_mode, config_active, mode_locked,
    input  ready
  );
  modport sink (
    input  valid, reply_byte, responding, current_mode, config_active, mode_locked,
    output ready
  );
endinterface

/* hw/rtl/gsr_in_reg.sv */
// ----------------------------------------------------------------------------
// Gamepad serial responder input register
// Holds one accepted host transfer until the engine consumes it.
// ----------------------------------------------------------------------------
module gsr_in_reg import gsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gsr_item_t in_item,
  input  logic      take,
  output logic      item_valid,
  output gsr_item_t item
);

  logic      vld_r;
  logic      vld_nxt;
  gsr_item_t item_r;

  assign in_ready   = !vld_r || take;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* hw/rtl/gsr_engine.sv */
// ----------------------------------------------------------------------------
// Gamepad serial responder engine
// Frame state machine, settings registers and reply byte selection.
// ----------------------------------------------------------------------------
module gsr_engine import gsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  gsr_item_t   item,
  output gsr_result_t result
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       cfg_r, cfg_nxt;
  logic       lock_r, lock_nxt;
  gsr_motor_t motor_r, motor_nxt;
  gsr_press_t press_r, press_nxt;
  gsr_snap_t  snap_r, snap_nxt;
  logic [7:0] qoff_r, qoff_nxt;
  logic [4:0] flen_r, flen_nxt;
  logic       fcfg_r, fcfg_nxt;

  logic [7:0] hb;
  logic [4:0] cmd_len;
  logic [4:0] poll_len;
  logic       any_press;
  logic [7:0] reply;
  logic       resp;

  function automatic logic [7:0] press_byte(input logic b);
    return b ? 8'h00 : 8'hFF;
  endfunction

  function automatic logic [7:0] poll_byte(input logic [4:0] p, input gsr_snap_t s);
    logic [7:0] r;
    case (p)
      5'd0:    r = BYTE_ACK;
      5'd1:    r = s[0];
      5'd2:    r = s[1];
      5'd3:    r = s[2];
      5'd4:    r = s[3];
      5'd5:    r = s[4];
      5'd6:    r = s[5];
      5'd7:    r = press_byte(s[0][5]);
      5'd8:    r = press_byte(s[0][7]);
      5'd9:    r = press_byte(s[0][4]);
      5'd10:   r = press_byte(s[0][6]);
      5'd11:   r = press_byte(s[1][4]);
      5'd12:   r = press_byte(s[1][5]);
      5'd13:   r = press_byte(s[1][6]);
      5'd14:   r = press_byte(s[1][7]);
      5'd15:   r = press_byte(s[1][2]);
      5'd16:   r = press_byte(s[1][3]);
      5'd17:   r = s[6];
      5'd18:   r = s[7];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(
    input logic [7:0] c,
    input logic [4:0] p,
    input logic [1:0] m,
    input logic [7:0] q,
    input gsr_motor_t mm,
    input gsr_snap_t  s,
    input logic       fc
  );
    logic       dig;
    logic       q0;
    logic [7:0] r;
    dig = (m != PAD_ANALOG) && (m != PAD_PRESSURE);
    q0  = (q == 8'h00);
    r   = 8'h00;
    if (p == 5'd0) begin
      r = BYTE_ACK;
    end else begin
      case (c)
        CMD_READ_PAD: r = poll_byte(p, s);
        CMD_SETUP: r = fc ? 8'h00 : poll_byte(p, s);
        CMD_BUTTON_MASK: begin
          if (p == 5'd3) r = 8'h02;
          if (p == 5'd6) r = BYTE_ACK;
        end
        CMD_STATUS_A: begin
          if (!dig) begin
            case (p)
              5'd1, 5'd2: r = 8'hFF;
              5'd3:       r = 8'h03;
              5'd6:       r = BYTE_ACK;
              default:    r = 8'h00;
            endcase
          end
        end
        CMD_STATUS_B: begin
          case (p)
            5'd1:    r = 8'h03;
            5'd2:    r = 8'h02;
            5'd3:    r = dig ? 8'h00 : 8'h01;
            5'd4:    r = 8'h02;
            5'd5:    r = 8'h01;
            default: r = 8'h00;
          endcase
        end
        CMD_CONST_A: begin
          case (p)
            5'd3:    r = 8'h01;
            5'd4:    r = q0 ? 8'h02 : 8'h01;
            5'd5:    r = q0 ? 8'h00 : 8'h01;
            5'd6:    r = 8'h0F;
            default: r = 8'h00;
          endcase
        end
        CMD_CONST_B: begin
          if (p == 5'd3) r = 8'h02;
          if (p == 5'd5) r = 8'h01;
        end
        CMD_CONST_C: begin
          if (p == 5'd4) r = q0 ? 8'h04 : 8'h07;
        end
        CMD_MOTOR_MAP: begin
          case (p)
            5'd1:    r = mm[0];
            5'd2:    r = mm[1];
            5'd3:    r = mm[2];
            5'd4:    r = mm[3];
            5'd5:    r = mm[4];
            5'd6:    r = mm[5];
            default: r = 8'h00;
          endcase
        end
        CMD_PRESS_EN: begin
          if (p == 5'd6) r = BYTE_ACK;
        end
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  assign hb = item.host_byte;

  always_comb begin
    case (mode_r)
      PAD_ANALOG:   poll_len = LEN_ANALOG;
      PAD_PRESSURE: poll_len = LEN_PRESSURE;
      default:      poll_len = LEN_DIGITAL;
    endcase
  end

  always_comb begin
    case (hb)
      CMD_READ_PAD: cmd_len = poll_len;
      CMD_SETUP:    cmd_len = cfg_r ? LEN_CONFIG : poll_len;
      CMD_BUTTON_MASK, CMD_STATUS_A, CMD_ANALOG_SW, CMD_STATUS_B, CMD_CONST_A,
      CMD_CONST_B, CMD_CONST_C, CMD_MOTOR_MAP, CMD_PRESS_EN:
        cmd_len = cfg_r ? LEN_CONFIG : 5'd0;
      default:    cmd_len = 5'd0;
    endcase
  end

  assign any_press = |press_r;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    pos_nxt   = pos_r;
    mode_nxt  = mode_r;
    cfg_nxt   = cfg_r;
    lock_nxt  = lock_r;
    motor_nxt = motor_r;
    press_nxt = press_r;
    snap_nxt  = snap_r;
    qoff_nxt  = qoff_r;
    flen_nxt  = flen_r;
    fcfg_nxt  = fcfg_r;
    reply     = 8'h00;
    resp      = 1'b0;

    if (item.restart) begin
      phase_nxt = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_CMD: begin
          cmd_nxt  = hb;
          snap_nxt = {item.right_trigger_level, item.left_trigger_level,
                      item.left_stick_y, item.left_stick_x,
                      item.right_stick_y, item.right_stick_x,
                      item.buttons_second, item.buttons_first};
          fcfg_nxt = cfg_r;
          if (hb == CMD_READ_PAD) cfg_nxt = 1'b0;
          flen_nxt = cmd_len;
          pos_nxt  = 5'd0;
          if (cmd_len != 5'd0) begin
            phase_nxt = PH_PAY;
            reply     = BYTE_ACK;
            resp      = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_PAY: begin
          case (cmd_r)
            CMD_SETUP: begin
              if (pos_r == 5'd1) cfg_nxt = (hb != 8'h00);
            end
            CMD_ANALOG_SW: begin
              if (pos_r == 5'd1) begin
                mode_nxt = (hb == ANALOG_ON) ?
                           (any_press ? PAD_PRESSURE : PAD_ANALOG) : PAD_DIGITAL;
              end else if (pos_r == 5'd2) begin
                lock_nxt = (hb == LOCK_KEY);
              end
            end
            CMD_CONST_A, CMD_CONST_C: begin
              if (pos_r == 5'd1) qoff_nxt = hb;
            end
            CMD_MOTOR_MAP: begin
              case (pos_r)
                5'd1:    motor_nxt[0] = hb;
                5'd2:    motor_nxt[1] = hb;
                5'd3:    motor_nxt[2] = hb;
                5'd4:    motor_nxt[3] = hb;
                5'd5:    motor_nxt[4] = hb;
                5'd6:    motor_nxt[5] = hb;
                default: motor_nxt = motor_r;
              endcase
            end
            CMD_PRESS_EN: begin
              case (pos_r)
                5'd1:    press_nxt[0] = hb;
                5'd2:    press_nxt[1] = hb;
                5'd3:    press_nxt[2] = hb;
                5'd4:    press_nxt[3] = hb;
                5'd6:    mode_nxt = any_press ? PAD_PRESSURE : PAD_ANALOG;
                default: press_nxt = press_r;
              endcase
            end
            default: cfg_nxt = cfg_r;
          endcase
          pos_nxt = pos_r + 5'd1;
          if (pos_nxt < flen_r) begin
            reply = frame_byte(cmd_r, pos_nxt, mode_nxt, qoff_nxt, motor_nxt,
                               snap_r, fcfg_r);
            resp  = 1'b1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (hb == HOST_START) begin
            phase_nxt = PH_CMD;
            resp      = 1'b1;
            if (cfg_r) begin
              reply = ID_CONFIG;
            end else begin
              case (mode_r)
                PAD_ANALOG:   reply = ID_ANALOG;
                PAD_PRESSURE: reply = ID_PRESSURE;
                default:      reply = ID_DIGITAL;
              endcase
            end
          end
        end
      endcase
    end
  end

  assign result.reply_byte    = reply;
  assign result.responding    = resp;
  assign result.current_mode  = mode_nxt;
  assign result.config_active = cfg_nxt;
  assign result.mode_locked   = lock_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= 8'h00;
      pos_r   <= 5'd0;
      mode_r  <= PAD_DIGITAL;
      cfg_r   <= 1'b0;
      lock_r  <= 1'b0;
      motor_r <= {6{8'hFF}};
      press_r <= {8'h00, 8'h03, 8'hFF, 8'hFF};
      snap_r  <= '0;
      qoff_r  <= 8'h00;
      flen_r  <= 5'd0;
      fcfg_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      cfg_r   <= cfg_nxt;
      lock_r  <= lock_nxt;
      motor_r <= motor_nxt;
      press_r <= press_nxt;
      snap_r  <= snap_nxt;
      qoff_r  <= qoff_nxt;
      flen_r  <= flen_nxt;
      fcfg_r  <= fcfg_nxt;
    end
  end

endmodule

/* hw/rtl/gsr_out_reg.sv */
// ----------------------------------------------------------------------------
// Gamepad serial responder output register
// Holds one reply transfer until the sink takes it.
// ----------------------------------------------------------------------------
module gsr_out_reg import gsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  gsr_result_t result,
  output logic        take,
  output logic        out_valid,
  input  logic        out_ready,
  output gsr_result_t out_result
);

  logic        vld_r;
  logic        vld_nxt;
  gsr_result_t res_r;

  assign take       = item_valid && (!vld_r || out_ready);
  assign out_valid  = vld_r;
  assign out_result = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= result;
    end
  end

endmodule

/* hw/rtl/gamepad_serial_responder.sv */
// ----------------------------------------------------------------------------
// Gamepad serial responder
// Device side of the console gamepad byte exchange: one reply per host byte.
//
//   Channel   Direction   Carries
//   in_ch     sink        restart, host byte and the pad values
//   out_ch    source      reply byte, responding flag, mode, config and lock
//
// An item passes from the input register through the combinational engine,
// which writes the output register and steps its own state on that transfer.
// A new item is accepted every cycle while the output side keeps up.
// A stalled output holds its reply; the input register then fills and stops.
// Reset is synchronous and restores idle phase, digital mode and the defaults.
// ----------------------------------------------------------------------------
module gamepad_serial_responder import gsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gsr_in_if.sink    in_ch,
  gsr_out_if.source out_ch
);

  gsr_item_t   in_item;
  gsr_item_t   item;
  gsr_result_t result;
  gsr_result_t out_result;
  logic        item_valid;
  logic        take;

  assign in_item.restart             = in_ch.restart;
  assign in_item.host_byte           = in_ch.host_byte;
  assign in_item.buttons_first       = in_ch.buttons_first;
  assign in_item.buttons_second      = in_ch.buttons_second;
  assign in_item.right_stick_x       = in_ch.right_stick_x;
  assign in_item.right_stick_y       = in_ch.right_stick_y;
  assign in_item.left_stick_x        = in_ch.left_stick_x;
  assign in_item.left_stick_y        = in_ch.left_stick_y;
  assign in_item.left_trigger_level  = in_ch.left_trigger_level;
  assign in_item.right_trigger_level = in_ch.right_trigger_level;

  gsr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  gsr_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (take),
    .item   (item),
    .result (result)
  );

  gsr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .take       (take),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign out_ch.reply_byte    = out_result.reply_byte;
  assign out_ch.responding    = out_result.responding;
  assign out_ch.current_mode  = out_result.current_mode;
  assign out_ch.config_active = out_result.config_active;
  assign out_ch.mode_locked   = out_result.mode_locked;

endmodule
